// ----- rtl/evg_pkg.sv -----
// ----------------------------------------------------------------------------
// evg_pkg
// Shared constants and the sequencer state type of the ellipse vertex
// generator.
// ----------------------------------------------------------------------------
package evg_pkg;

  localparam int MAX_QUARTER_POINTS_DEF = 17;
  localparam int FRAC_BITS_DEF          = 16;
  localparam int COORD_W                = 32;
  localparam int COUNT_W                = 8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQR_LD,
    ST_SQR,
    ST_RT_LD,
    ST_RT,
    ST_MX_LD,
    ST_MX,
    ST_MY_LD,
    ST_MY,
    ST_EMIT
  } evg_state_t;

endpackage

// ----- rtl/ellipse_vertex_generator_core.sv -----
// ----------------------------------------------------------------------------
// ellipse_vertex_generator_core
// Emits the 4(n-1) polygon vertices of an axis-aligned ellipse, one bit per
// cycle through a serial divider, a serial multiplier and a serial root.
// Each vertex passes the radix-2 divider, the square, the bit-pair root and the
//   width and height products in turn; the square and both products share one
//   shift-add multiplier. Work on a vertex starts only once the previous one
//   has entered the output register. A new transaction starts while the last
//   vertex still waits in the output register.
// Reset: synchronous, active low; returns to idle with no result pending.
// ----------------------------------------------------------------------------
module ellipse_vertex_generator_core
  import evg_pkg::*;
#(
  parameter int MAX_QUARTER_POINTS = MAX_QUARTER_POINTS_DEF,
  parameter int FRAC_BITS          = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [COORD_W-1:0]        in_full_width,
  input  logic [COORD_W-1:0]        in_full_height,
  input  logic [COUNT_W-1:0]        in_quarter_points,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] out_vertex_x,
  output logic signed [COORD_W-1:0] out_vertex_y,
  output logic                      out_last_vertex
);

  localparam int F       = FRAC_BITS;
  localparam int SEG_MAX = MAX_QUARTER_POINTS - 1;
  localparam int SW      = (SEG_MAX > 1) ? $clog2(SEG_MAX + 1) : 1;
  localparam int IW      = SW + 1;
  localparam int DW      = IW + F;
  localparam int NW      = F + 1;
  localparam int MW      = COORD_W + NW;
  localparam int CW      = $clog2(DW);

  localparam logic [NW-1:0] ONE    = {1'b1, {F{1'b0}}};
  localparam logic [DW-1:0] ONE_DW = {{(DW - NW){1'b0}}, ONE};
  localparam logic [CW-1:0] DIV_LAST = CW'(DW - 1);
  localparam logic [CW-1:0] BIT_LAST = CW'(NW - 1);
  localparam logic [COUNT_W-1:0] N_MAX = COUNT_W'(MAX_QUARTER_POINTS);
  localparam logic [COUNT_W-1:0] N_MIN = COUNT_W'(2);

  evg_state_t state_r, state_nxt;

  logic [COORD_W-1:0] w_r, w_nxt, h_r, h_nxt;
  logic [SW-1:0]      seg_r, seg_nxt;
  logic [IW-1:0]      k_r, k_nxt;
  logic               lower_r, lower_nxt;
  logic [DW-1:0]      div_r, div_nxt;
  logic [SW-1:0]      drem_r, drem_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [COORD_W-1:0] mcand_r, mcand_nxt;
  logic [NW-1:0]      mplr_r, mplr_nxt;
  logic [MW-1:0]      acc_r, acc_nxt;
  logic [2*NW-1:0]    rad_r, rad_nxt;
  logic [NW-1:0]      root_r, root_nxt;
  logic [NW+1:0]      rrem_r, rrem_nxt;
  logic [NW-1:0]      xmag_r, xmag_nxt;
  logic               xneg_r, xneg_nxt;
  logic [COORD_W-1:0] xres_r, xres_nxt;
  logic [COORD_W-1:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               in_acc, out_free, cnt_done, last_c;
  logic [COUNT_W-1:0] n_sat;
  logic [IW-1:0]      half_c, k_step;
  logic               lower_step;
  logic [SW:0]        drem_sh;
  logic               div_ge;
  logic               xneg_c;
  logic [DW-1:0]      dmag_c;
  logic [NW-1:0]      xmag_c, x2_c, s_c;
  logic [MW-1:0]      acc_step;
  logic [NW+3:0]      rsh_c, trial_c;
  logic               rt_ge;

  function automatic logic [COORD_W-1:0] half_scale(input logic [MW-1:0] mag,
                                                    input logic neg);
    logic [COORD_W-1:0] q;
    q = mag[MW-1:F+1];
    if (neg) begin
      q = q + COORD_W'(|mag[F:0]);
      q = '0 - q;
    end
    return q;
  endfunction

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign cnt_done = (cnt_r == '0);

  assign n_sat = (in_quarter_points < N_MIN) ? N_MIN :
                 (in_quarter_points > N_MAX) ? N_MAX : in_quarter_points;

  // vertex order: upper half ascending, then lower half descending
  assign half_c = {seg_r, 1'b0};
  assign last_c = lower_r && (k_r == IW'(1));
  always_comb begin
    lower_step = lower_r;
    k_step     = k_r;
    if (!lower_r) begin
      if (k_r == half_c - IW'(1)) begin
        lower_step = 1'b1;
        k_step     = half_c;
      end else begin
        k_step = k_r + IW'(1);
      end
    end else begin
      k_step = k_r - IW'(1);
    end
  end

  // restoring divider step
  assign drem_sh = {drem_r, div_r[DW-1]};
  assign div_ge  = (drem_sh >= {1'b0, seg_r});

  // abscissa magnitude from quotient
  assign xneg_c = (div_r < ONE_DW);
  assign dmag_c = xneg_c ? (ONE_DW - div_r) : (div_r - ONE_DW);
  assign xmag_c = (dmag_c > ONE_DW) ? ONE : dmag_c[NW-1:0];

  // msb-first shift-add multiplier step
  assign acc_step = {acc_r[MW-2:0], 1'b0} +
                    (mplr_r[NW-1] ? {{NW{1'b0}}, mcand_r} : MW'(0));

  // 1 - x^2 from the square
  assign x2_c = acc_r[F+NW-1:F];
  assign s_c  = ONE - x2_c;

  // bit-pair square root step
  assign rsh_c   = {rrem_r, rad_r[2*NW-1 -: 2]};
  assign trial_c = {2'b00, root_r, 2'b01};
  assign rt_ge   = (rsh_c >= trial_c);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_DIV;
      ST_DIV:    if (cnt_done) state_nxt = ST_SQR_LD;
      ST_SQR_LD: state_nxt = ST_SQR;
      ST_SQR:    if (cnt_done) state_nxt = ST_RT_LD;
      ST_RT_LD:  state_nxt = ST_RT;
      ST_RT:     if (cnt_done) state_nxt = ST_MX_LD;
      ST_MX_LD:  state_nxt = ST_MX;
      ST_MX:     if (cnt_done) state_nxt = ST_MY_LD;
      ST_MY_LD:  state_nxt = ST_MY;
      ST_MY:     if (cnt_done) state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_nxt = last_c ? ST_IDLE : ST_DIV;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    w_nxt        = w_r;
    h_nxt        = h_r;
    seg_nxt      = seg_r;
    k_nxt        = k_r;
    lower_nxt    = lower_r;
    div_nxt      = div_r;
    drem_nxt     = drem_r;
    cnt_nxt      = cnt_r;
    mcand_nxt    = mcand_r;
    mplr_nxt     = mplr_r;
    acc_nxt      = acc_r;
    rad_nxt      = rad_r;
    root_nxt     = root_r;
    rrem_nxt     = rrem_r;
    xmag_nxt     = xmag_r;
    xneg_nxt     = xneg_r;
    xres_nxt     = xres_r;
    out_x_nxt    = out_x_r;
    out_y_nxt    = out_y_r;
    out_last_nxt = out_last_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          w_nxt     = in_full_width;
          h_nxt     = in_full_height;
          seg_nxt   = SW'(n_sat - COUNT_W'(1));
          k_nxt     = '0;
          lower_nxt = 1'b0;
          div_nxt   = '0;
          drem_nxt  = '0;
          cnt_nxt   = DIV_LAST;
        end
      end
      ST_DIV: begin
        drem_nxt = div_ge ? SW'(drem_sh - {1'b0, seg_r}) : drem_sh[SW-1:0];
        div_nxt  = {div_r[DW-2:0], div_ge};
        cnt_nxt  = cnt_r - CW'(1);
      end
      ST_SQR_LD: begin
        xmag_nxt  = xmag_c;
        xneg_nxt  = xneg_c;
        mcand_nxt = {{(COORD_W - NW){1'b0}}, xmag_c};
        mplr_nxt  = xmag_c;
        acc_nxt   = '0;
        cnt_nxt   = BIT_LAST;
      end
      ST_SQR, ST_MX, ST_MY: begin
        acc_nxt  = acc_step;
        mplr_nxt = {mplr_r[NW-2:0], 1'b0};
        cnt_nxt  = cnt_r - CW'(1);
      end
      ST_RT_LD: begin
        rad_nxt  = {1'b0, s_c, {F{1'b0}}};
        root_nxt = '0;
        rrem_nxt = '0;
        cnt_nxt  = BIT_LAST;
      end
      ST_RT: begin
        rrem_nxt = rt_ge ? (NW+2)'(rsh_c - trial_c) : rsh_c[NW+1:0];
        root_nxt = {root_r[NW-2:0], rt_ge};
        rad_nxt  = {rad_r[2*NW-3:0], 2'b00};
        cnt_nxt  = cnt_r - CW'(1);
      end
      ST_MX_LD: begin
        root_nxt  = (root_r > ONE) ? ONE : root_r;
        mcand_nxt = w_r;
        mplr_nxt  = xmag_r;
        acc_nxt   = '0;
        cnt_nxt   = BIT_LAST;
      end
      ST_MY_LD: begin
        xres_nxt  = half_scale(acc_r, xneg_r);
        mcand_nxt = h_r;
        mplr_nxt  = root_r;
        acc_nxt   = '0;
        cnt_nxt   = BIT_LAST;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_x_nxt     = xres_r;
          out_y_nxt     = half_scale(acc_r, lower_r);
          out_last_nxt  = last_c;
          out_valid_nxt = 1'b1;
          k_nxt         = k_step;
          lower_nxt     = lower_step;
          div_nxt       = {k_step, {F{1'b0}}};
          drem_nxt      = '0;
          cnt_nxt       = DIV_LAST;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r        <= w_nxt;
    h_r        <= h_nxt;
    seg_r      <= seg_nxt;
    k_r        <= k_nxt;
    lower_r    <= lower_nxt;
    div_r      <= div_nxt;
    drem_r     <= drem_nxt;
    mcand_r    <= mcand_nxt;
    mplr_r     <= mplr_nxt;
    acc_r      <= acc_nxt;
    rad_r      <= rad_nxt;
    root_r     <= root_nxt;
    rrem_r     <= rrem_nxt;
    xmag_r     <= xmag_nxt;
    xneg_r     <= xneg_nxt;
    xres_r     <= xres_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_vertex_x    = $signed(out_x_r);
  assign out_vertex_y    = $signed(out_y_r);
  assign out_last_vertex = out_last_r;

  a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_DIV) && (k_r == '0) && !lower_r)
    else $error("transaction accept did not start the vertex run at index zero");

  a_xmag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQR) |-> (xmag_r <= ONE))
    else $error("normalized abscissa magnitude above one");

  a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MY_LD) |-> (root_r <= ONE))
    else $error("square root result above one");

  a_last_lower: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_vertex_y <= 0))
    else $error("final vertex not in the lower half");

endmodule
